// ----- src/algd_pkg.sv -----
// Shared types and constants for the adjacency-list graph search block.
// No dependencies.
package algd_pkg;

   localparam int NUM_VERTICES = 16;
   localparam int MAX_DEGREE   = 4;
   localparam int VW = $clog2(NUM_VERTICES);          // vertex index width
   localparam int EW = $clog2(MAX_DEGREE);            // edge slot width
   localparam int DW = $clog2(MAX_DEGREE + 1);        // degree count width
   localparam int LW = $clog2(NUM_VERTICES + 1);      // label width
   localparam int SW = $clog2(NUM_VERTICES + 1);      // stack pointer width

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_SEARCH = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_VTX  = 2'd1,
      ST_FULL     = 2'd2,
      ST_NO_EDGE  = 2'd3
   } status_type;

endpackage

// ----- src/adjacency_list_graph_dfs.sv -----
// Adjacency-list graph store with edge insert/remove and depth-first search.
// Depends on algd_pkg.
//
// Channels: req_ (slave) takes one command word: tdata = {directed, target,
// origin, func}. rsp_ (master) returns result words: tdata = {label, vertex,
// status}, tlast marks the final word of a command. csr_ writes
// vertices_in_use (5 bits); the user must write it only while the block is
// idle, as the block does not enforce it. One command is handled at a time;
// req_tready is high when idle and the output register is empty, so the next
// command is taken the cycle after the last word of the previous one leaves.
// Insert: appends to the origin list in S_INS (and to the target list in a
// second S_INS when undirected); S_DONE posts the status word. Remove:
// S_RM_RD/S_RM_CHK scan the list through the neighbor memory; on a match
// S_RM_LAST reads the last entry and S_RM_MOVE moves it into the gap; an
// undirected remove repeats this for the reverse list. Search: S_CLR clears,
// then each edge costs a memory read (S_TOP) and a label check (S_NB_CHK), each
// pop and the final empty-stack check an S_TOP; S_OUT sweeps one word per vertex.
// Reset clears degrees, sets vertices_in_use to 16 and empties the output.
// Results sit in a one-word output register; while rsp_tready is low the
// engine holds in place and resumes when the word is taken.
module adjacency_list_graph_dfs
   import algd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // func[1:0], origin[5:2], target[9:6], directed[10]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // status[1:0], vertex_index[5:2], depth_label[10:6]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_INS, S_RM_RD, S_RM_CHK, S_RM_LAST, S_RM_MOVE,
      S_CLR, S_TOP, S_NB_CHK, S_OUT, S_DONE
   } state_type;

   state_type          state_ff;
   logic [4:0]         viu_ff;
   logic [DW-1:0]      deg_ff [NUM_VERTICES];
   logic [LW-1:0]      lab_ff [NUM_VERTICES];
   logic [VW-1:0]      stk_v_ff [NUM_VERTICES];
   logic [DW-1:0]      stk_n_ff [NUM_VERTICES];
   logic [SW-1:0]      sp_ff;
   // neighbor memory, one read port registered
   logic [VW-1:0]      nbr_mem [NUM_VERTICES*MAX_DEGREE];
   logic [VW-1:0]      nbr_rd_ff;
   logic [VW+EW-1:0]   rd_addr;
   logic               wr_en;
   logic [VW+EW-1:0]   wr_addr;
   logic [VW-1:0]      wr_data;

   logic [VW-1:0]      org_ff, tgt_ff;
   logic               dir_ff, second_ff;
   logic [DW-1:0]      idx_ff;
   logic [EW-1:0]      gap_ff;
   logic [VW:0]        cnt_ff;
   logic               ov_ff;
   logic               ov_in;
   logic [1:0]         ost_ff;
   logic [VW-1:0]      ovx_ff;
   logic [LW-1:0]      olb_ff;
   logic               olast_ff;

   logic [VW:0]        nvalid;
   logic [VW-1:0]      r_org, r_tgt;
   logic [1:0]         r_func;
   logic               take_out;
   logic [VW-1:0]      top_v;
   logic [DW-1:0]      top_n;
   logic [VW-1:0]      cur_from, cur_to;

   assign nvalid = (viu_ff > 5'(NUM_VERTICES)) ? (VW+1)'(NUM_VERTICES) : viu_ff[VW:0];
   assign r_func = req_tdata[1:0];
   assign r_org  = req_tdata[5:2];
   assign r_tgt  = req_tdata[9:6];
   assign req_tready = (state_ff == S_IDLE) && !ov_ff;
   assign csr_ready  = 1'b1;
   assign take_out   = !ov_ff || rsp_tready;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {5'd0, olb_ff, ovx_ff, ost_ff};
   assign rsp_tlast  = olast_ff;
   assign top_v = stk_v_ff[sp_ff[VW-1:0] - VW'(1)];
   assign top_n = stk_n_ff[sp_ff[VW-1:0] - VW'(1)];
   // current list pass of an insert or remove: forward then reverse
   assign cur_from = second_ff ? tgt_ff : org_ff;
   assign cur_to   = second_ff ? org_ff : tgt_ff;
   // output word loaded, or still waiting for the receiver
   assign ov_in = ((state_ff == S_OUT || state_ff == S_DONE) && take_out) ||
                  (ov_ff && !rsp_tready);

   // read address for the neighbor memory
   always_comb begin
      rd_addr = {cur_from, idx_ff[EW-1:0]};
      if (state_ff == S_TOP)
         rd_addr = {top_v, top_n[EW-1:0]};
      else if (state_ff == S_RM_LAST)
         rd_addr = {cur_from, EW'(deg_ff[cur_from] - DW'(1))};
   end

   // memory write for insert (append) and remove (fill the gap)
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {cur_from, gap_ff};
      wr_data = nbr_rd_ff;
      if (state_ff == S_INS) begin
         wr_en   = 1'b1;
         wr_addr = {cur_from, deg_ff[cur_from][EW-1:0]};
         wr_data = cur_to;
      end else if (state_ff == S_RM_MOVE) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en)
         nbr_mem[wr_addr] <= wr_data;
      nbr_rd_ff <= nbr_mem[rd_addr];
   end

   // control sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         viu_ff   <= 5'd16;
         ov_ff    <= 1'b0;
         sp_ff    <= '0;
         for (int i = 0; i < NUM_VERTICES; i++) deg_ff[i] <= '0;
      end else begin
         ov_ff <= ov_in;
         if (csr_valid) viu_ff <= csr_data;
         unique case (state_ff)
            S_IDLE: if (req_tvalid && req_tready) begin
               org_ff    <= r_org;
               tgt_ff    <= r_tgt;
               dir_ff    <= req_tdata[10];
               second_ff <= 1'b0;
               idx_ff    <= '0;
               cnt_ff    <= '0;
               ost_ff    <= ST_OK;
               ovx_ff    <= '0;
               olb_ff    <= '0;
               olast_ff  <= 1'b1;
               if (r_func == FUNC_NONE) begin
                  state_ff <= S_DONE;
               end else if ({1'b0, r_org} >= nvalid ||
                            (r_func != FUNC_SEARCH && {1'b0, r_tgt} >= nvalid)) begin
                  ost_ff   <= ST_BAD_VTX;
                  state_ff <= S_DONE;
               end else if (r_func == FUNC_INSERT) begin
                  if ((32'(deg_ff[r_org]) + ((!req_tdata[10] && r_org == r_tgt) ? 2 : 1))
                        > MAX_DEGREE ||
                      (!req_tdata[10] && r_org != r_tgt &&
                       32'(deg_ff[r_tgt]) >= MAX_DEGREE)) begin
                     ost_ff   <= ST_FULL;
                     state_ff <= S_DONE;
                  end else
                     state_ff <= S_INS;
               end else if (r_func == FUNC_REMOVE) begin
                  state_ff <= S_RM_RD;
               end else begin
                  state_ff <= S_CLR;
               end
            end
            S_INS: begin
               deg_ff[cur_from] <= deg_ff[cur_from] + DW'(1);
               if (!dir_ff && !second_ff) second_ff <= 1'b1;
               else state_ff <= S_DONE;
            end
            S_RM_RD: begin
               if (idx_ff >= deg_ff[cur_from]) begin
                  if (!second_ff) ost_ff <= ST_NO_EDGE;
                  state_ff <= S_DONE;
               end else
                  state_ff <= S_RM_CHK;
            end
            S_RM_CHK: begin
               if (nbr_rd_ff == cur_to) begin
                  gap_ff   <= idx_ff[EW-1:0];
                  state_ff <= S_RM_LAST;
               end else begin
                  idx_ff   <= idx_ff + DW'(1);
                  state_ff <= S_RM_RD;
               end
            end
            S_RM_LAST: state_ff <= S_RM_MOVE;
            S_RM_MOVE: begin
               deg_ff[cur_from] <= deg_ff[cur_from] - DW'(1);
               idx_ff <= '0;
               if (!dir_ff && !second_ff) begin
                  second_ff <= 1'b1;
                  state_ff  <= S_RM_RD;
               end else
                  state_ff <= S_DONE;
            end
            S_CLR: begin
               // start vertex gets label 1, all others unreached
               for (int i = 0; i < NUM_VERTICES; i++)
                  lab_ff[i] <= (VW'(i) == org_ff) ? LW'(1) : '0;
               stk_v_ff[0] <= org_ff;
               stk_n_ff[0] <= '0;
               sp_ff    <= SW'(1);
               state_ff <= S_TOP;
            end
            S_TOP: begin
               if (sp_ff == '0) begin
                  cnt_ff   <= '0;
                  state_ff <= S_OUT;
               end else if (top_n >= deg_ff[top_v]) begin
                  sp_ff <= sp_ff - SW'(1);
               end else begin
                  stk_n_ff[sp_ff[VW-1:0] - VW'(1)] <= top_n + DW'(1);
                  state_ff <= S_NB_CHK;
               end
            end
            S_NB_CHK: begin
               if ({1'b0, nbr_rd_ff} < nvalid && lab_ff[nbr_rd_ff] == '0 &&
                   sp_ff < SW'(NUM_VERTICES)) begin
                  lab_ff[nbr_rd_ff] <= lab_ff[top_v] + LW'(1);
                  stk_v_ff[sp_ff[VW-1:0]] <= nbr_rd_ff;
                  stk_n_ff[sp_ff[VW-1:0]] <= '0;
                  sp_ff <= sp_ff + SW'(1);
               end
               state_ff <= S_TOP;
            end
            S_OUT: if (take_out) begin
               ost_ff   <= ST_OK;
               ovx_ff   <= cnt_ff[VW-1:0];
               olb_ff   <= lab_ff[cnt_ff[VW-1:0]];
               olast_ff <= (cnt_ff + (VW+1)'(1) == nvalid);
               cnt_ff   <= cnt_ff + (VW+1)'(1);
               if (cnt_ff + (VW+1)'(1) == nvalid) state_ff <= S_IDLE;
            end
            S_DONE: if (take_out) begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // a result word stays valid and unchanged while the receiver stalls
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !rsp_tready |=> ov_ff && $stable(rsp_tdata))
      else $error("result word changed while stalled");
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SW'(NUM_VERTICES))
      else $error("walk stack overflow");
   a_deg_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_INS |-> deg_ff[cur_from] < DW'(MAX_DEGREE))
      else $error("append into a full list");
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == S_IDLE)
      else $error("ready while busy");

endmodule
